[rtl/pevq_pkg.sv]
package pevq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int BTN_W   = 9;
    localparam int POS_W   = 16;
    localparam int STAMP_W = 32;

    localparam int FORCE_BIT = 8;

    localparam int RING_POS_W = 2 * POS_W;
    localparam int RING_BT_W  = BTN_W + STAMP_W;

    localparam logic OP_TRACK = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FETCH
    } pevq_state_t;

endpackage

[rtl/pevq_ram.sv]
module pevq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pointer_event_queue_top.sv]
// Channel   Handshake              Fields
// command   start in, busy out     op buttons x_pos y_pos is_delta stamp_ms
// result    done out (one cycle)   has_event out_x out_y out_buttons out_stamp_ms
//
// Track commands give no result.
// A read with a ring entry to return passes ST_FETCH: the ring RAM read register, then the result registers.
// Any other read gives its result on done in the cycle after the transfer.
// rst_n clears pointers, pending mark and current state; the ring RAM is not cleared.
// The receiver cannot stall; done is high for exactly one cycle per result.
module pointer_event_queue_top #(
    parameter int QUEUE_DEPTH = pevq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [pevq_pkg::BTN_W-1:0]          buttons,
    input  logic signed [pevq_pkg::POS_W-1:0]   x_pos,
    input  logic signed [pevq_pkg::POS_W-1:0]   y_pos,
    input  logic                                is_delta,
    input  logic [pevq_pkg::STAMP_W-1:0]        stamp_ms,
    output logic                                done,
    output logic                                has_event,
    output logic signed [pevq_pkg::POS_W-1:0]   out_x,
    output logic signed [pevq_pkg::POS_W-1:0]   out_y,
    output logic [pevq_pkg::BTN_W-1:0]          out_buttons,
    output logic [pevq_pkg::STAMP_W-1:0]        out_stamp_ms
);

    import pevq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    pevq_state_t state_reg, state_next;

    logic [POS_W-1:0]   cur_x_reg, cur_y_reg;
    logic [BTN_W-1:0]   cur_btn_reg;
    logic [STAMP_W-1:0] cur_stamp_reg;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               full_reg, full_next;
    logic               pending_reg, pending_next;

    logic               done_reg, done_next;
    logic               has_event_reg, has_event_next;
    logic [POS_W-1:0]   out_x_reg, out_x_next;
    logic [POS_W-1:0]   out_y_reg, out_y_next;
    logic [BTN_W-1:0]   out_btn_reg, out_btn_next;
    logic [STAMP_W-1:0] out_stamp_reg, out_stamp_next;

    logic               accept, track_acc, read_acc;
    logic [POS_W-1:0]   new_x, new_y;
    logic               same, take, push, pop, ring_busy;

    logic [RING_POS_W-1:0] pos_rdata;
    logic [RING_BT_W-1:0]  bt_rdata;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign track_acc = accept && (op == OP_TRACK);
    assign read_acc  = accept && (op == OP_READ);

    assign new_x = is_delta ? (cur_x_reg + $unsigned(x_pos)) : $unsigned(x_pos);
    assign new_y = is_delta ? (cur_y_reg + $unsigned(y_pos)) : $unsigned(y_pos);

    assign same = !buttons[FORCE_BIT] && (new_x == cur_x_reg) && (new_y == cur_y_reg)
                  && (buttons == cur_btn_reg);
    assign take      = track_acc && !same;
    assign push      = take && !full_reg && (buttons != cur_btn_reg);
    assign ring_busy = full_reg || (rd_ptr_reg != wr_ptr_reg);
    assign pop       = read_acc && pending_reg && ring_busy;

    pevq_ram #(
        .WIDTH (RING_POS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata ({new_y, new_x}),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (pos_rdata)
    );

    pevq_ram #(
        .WIDTH (RING_BT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_bt_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata ({stamp_ms, buttons}),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (bt_rdata)
    );

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        full_next    = full_reg;
        pending_next = pending_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            full_next   = (wr_ptr_next == rd_ptr_reg);
        end
        if (take)
        begin
            pending_next = 1'b1;
        end
        if (read_acc)
        begin
            pending_next = 1'b0;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            full_next   = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        has_event_next = has_event_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_btn_next   = out_btn_reg;
        out_stamp_next = out_stamp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_FETCH;
                end
                else if (read_acc)
                begin
                    done_next      = 1'b1;
                    has_event_next = pending_reg;
                    out_x_next     = pending_reg ? cur_x_reg : '0;
                    out_y_next     = pending_reg ? cur_y_reg : '0;
                    out_btn_next   = pending_reg ? cur_btn_reg : '0;
                    out_stamp_next = pending_reg ? cur_stamp_reg : '0;
                end
            end
            ST_FETCH:
            begin
                state_next     = ST_IDLE;
                done_next      = 1'b1;
                has_event_next = 1'b1;
                out_x_next     = pos_rdata[POS_W-1:0];
                out_y_next     = pos_rdata[RING_POS_W-1:POS_W];
                out_btn_next   = bt_rdata[BTN_W-1:0];
                out_stamp_next = bt_rdata[RING_BT_W-1:BTN_W];
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_btn_reg   <= '0;
            cur_stamp_reg <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            full_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            full_reg    <= full_next;
            pending_reg <= pending_next;
            done_reg    <= done_next;
            if (take)
            begin
                cur_x_reg     <= new_x;
                cur_y_reg     <= new_y;
                cur_btn_reg   <= buttons;
                cur_stamp_reg <= stamp_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        has_event_reg <= has_event_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_btn_reg   <= out_btn_next;
        out_stamp_reg <= out_stamp_next;
    end

    assign done         = done_reg;
    assign has_event    = has_event_reg;
    assign out_x        = $signed(out_x_reg);
    assign out_y        = $signed(out_y_reg);
    assign out_buttons  = out_btn_reg;
    assign out_stamp_ms = out_stamp_reg;

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("ring full with pointers apart");

    a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |=> (done_reg && has_event_reg))
        else $error("ring fetch gave no event");

    a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> !push)
        else $error("ring write during fetch");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !has_event_reg) |-> ((out_x_reg == '0) && (out_y_reg == '0)
            && (out_btn_reg == '0) && (out_stamp_reg == '0)))
        else $error("empty result carries data");

    a_pop_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !pending_reg)
        else $error("pending mark kept after pop");

endmodule

[dv/pointer_event_queue_top_test.sv]
`timescale 1ns / 100ps

module pointer_event_queue_top_test;

    import pevq_pkg::*;

    localparam int DEPTH = DEFAULT_QUEUE_DEPTH;

    typedef struct packed {
        logic               has_event;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [BTN_W-1:0]   btn;
        logic [STAMP_W-1:0] stamp;
    } pointer_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic op = OP_TRACK;
    logic [BTN_W-1:0] buttons = '0;
    logic signed [POS_W-1:0] x_pos = '0;
    logic signed [POS_W-1:0] y_pos = '0;
    logic is_delta = 1'b0;
    logic [STAMP_W-1:0] stamp_ms = '0;
    logic done;
    logic has_event;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic [BTN_W-1:0] out_buttons;
    logic [STAMP_W-1:0] out_stamp_ms;

    pointer_event_queue_top #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .buttons      (buttons),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .is_delta     (is_delta),
        .stamp_ms     (stamp_ms),
        .done         (done),
        .has_event    (has_event),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_buttons  (out_buttons),
        .out_stamp_ms (out_stamp_ms)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Pointer state as the block should hold it
    logic [POS_W-1:0]   cur_x;
    logic [POS_W-1:0]   cur_y;
    logic [BTN_W-1:0]   cur_btn;
    logic [STAMP_W-1:0] cur_stamp;
    logic [POS_W-1:0]   ring_x [DEPTH];
    logic [POS_W-1:0]   ring_y [DEPTH];
    logic [BTN_W-1:0]   ring_btn [DEPTH];
    logic [STAMP_W-1:0] ring_stamp [DEPTH];
    int                 rd_ptr;
    int                 wr_ptr;
    logic               ring_full;
    logic               pending;

    pointer_event_t read_results_due[$];
    pointer_event_t arrived_due;
    int             mismatches = 0;

    task automatic apply_track(input logic [BTN_W-1:0] btn, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic delta,
                               input logic [STAMP_W-1:0] stamp);
        logic [POS_W-1:0] nx;
        logic [POS_W-1:0] ny;
        logic [BTN_W-1:0] prev_btn;
        nx = x;
        ny = y;
        if (delta)
        begin
            nx = nx + cur_x;
            ny = ny + cur_y;
        end
        if (!btn[FORCE_BIT] && nx == cur_x && ny == cur_y && btn == cur_btn)
            return;
        prev_btn = cur_btn;
        cur_x = nx;
        cur_y = ny;
        cur_btn = btn;
        cur_stamp = stamp;
        if (!ring_full && prev_btn != btn)
        begin
            ring_x[wr_ptr] = nx;
            ring_y[wr_ptr] = ny;
            ring_btn[wr_ptr] = btn;
            ring_stamp[wr_ptr] = stamp;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (wr_ptr == rd_ptr)
                ring_full = 1'b1;
        end
        pending = 1'b1;
    endtask

    task automatic next_event(output pointer_event_t evt);
        evt = '0;
        if (!pending)
            return;
        pending = 1'b0;
        evt.has_event = 1'b1;
        if (ring_full || rd_ptr != wr_ptr)
        begin
            evt.x = ring_x[rd_ptr];
            evt.y = ring_y[rd_ptr];
            evt.btn = ring_btn[rd_ptr];
            evt.stamp = ring_stamp[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            ring_full = 1'b0;
        end
        else
        begin
            evt.x = cur_x;
            evt.y = cur_y;
            evt.btn = cur_btn;
            evt.stamp = cur_stamp;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [STAMP_W-1:0] got,
                                   input logic [STAMP_W-1:0] want);
        mismatches++;
        $display("%0t: read result %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Call at a rising edge; returns at the edge of the transfer
    task automatic send_item(input logic op_i, input logic [BTN_W-1:0] btn,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic delta, input logic [STAMP_W-1:0] stamp);
        pointer_event_t evt;
        start <= 1'b1;
        op <= op_i;
        buttons <= btn;
        x_pos <= x;
        y_pos <= y;
        is_delta <= delta;
        stamp_ms <= stamp;
        do
            @(posedge clk);
        while (busy);
        if (op_i == OP_TRACK)
            apply_track(btn, x, y, delta, stamp);
        else
        begin
            next_event(evt);
            read_results_due.push_back(evt);
        end
    endtask

    task automatic send_track(input logic [BTN_W-1:0] btn, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic delta,
                              input logic [STAMP_W-1:0] stamp);
        send_item(OP_TRACK, btn, x, y, delta, stamp);
    endtask

    task automatic send_read();
        send_item(OP_READ, BTN_W'($urandom_range(0, 511)), POS_W'($urandom),
                  POS_W'($urandom), 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic idle_gap();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            n = 0;
        else if (sel < 88)
            n = $urandom_range(1, 3);
        else if (sel < 98)
            n = $urandom_range(4, 10);
        else
            n = $urandom_range(20, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every read result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (read_results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic random_track();
        logic [BTN_W-1:0] btn;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             delta;
        int               sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            btn = cur_btn;
        else if (sel < 8)
            btn = BTN_W'($urandom_range(0, 31));
        else if (sel == 8)
            btn = BTN_W'($urandom_range(0, 511));
        else
            btn = cur_btn | (BTN_W'(1) << FORCE_BIT);
        delta = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 3);
        if (sel == 0)
        begin
            x = delta ? '0 : cur_x;
            y = delta ? '0 : cur_y;
        end
        else if (sel == 1 && delta)
        begin
            x = POS_W'($urandom_range(0, 16) - 8);
            y = POS_W'($urandom_range(0, 16) - 8);
        end
        else
        begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
        end
        send_track(btn, x, y, delta, $urandom);
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            if (read_results_due.size() == 0)
                report_mismatch("with no read waiting, has_event", STAMP_W'(has_event),
                                '0);
            else
            begin
                arrived_due = read_results_due.pop_front();
                if (has_event !== arrived_due.has_event)
                    report_mismatch("has_event", STAMP_W'(has_event),
                                    STAMP_W'(arrived_due.has_event));
                if (out_x !== arrived_due.x)
                    report_mismatch("out_x", STAMP_W'($unsigned(out_x)),
                                    STAMP_W'(arrived_due.x));
                if (out_y !== arrived_due.y)
                    report_mismatch("out_y", STAMP_W'($unsigned(out_y)),
                                    STAMP_W'(arrived_due.y));
                if (out_buttons !== arrived_due.btn)
                    report_mismatch("out_buttons", STAMP_W'(out_buttons),
                                    STAMP_W'(arrived_due.btn));
                if (out_stamp_ms !== arrived_due.stamp)
                    report_mismatch("out_stamp_ms", out_stamp_ms, arrived_due.stamp);
            end
        end
    end

    task automatic test_read_with_nothing_pending();
        send_read();
        idle_gap();
        send_read();
        drain_results();
    endtask

    task automatic test_coalesce_and_force();
        send_track(9'h01F, 16'h8000, 16'h7FFF, 1'b0, 32'hFFFF_FFFF);
        send_read();
        // unchanged update: drop, keep old stamp
        send_track(9'h01F, 16'h8000, 16'h7FFF, 1'b0, 32'h0000_0001);
        send_read();
        // move only: no ring push, read returns current state
        send_track(9'h01F, 16'h0000, 16'h0000, 1'b0, 32'h0000_0002);
        send_track(9'h01F, 16'h1234, 16'hEDCB, 1'b0, 32'h0000_0003);
        send_read();
        send_read();
        send_track(9'h11F, 16'h1234, 16'hEDCB, 1'b0, 32'h0000_0004);
        send_track(9'h11F, 16'h1234, 16'hEDCB, 1'b0, 32'h0000_0005);
        send_read();
        send_track(9'h000, 16'h0001, 16'h0002, 1'b0, 32'h8000_0000);
        send_track(9'h0E0, 16'h0003, 16'h0004, 1'b0, 32'h7FFF_FFFF);
        send_read();
        // entry left in ring, but pending already cleared
        send_read();
        send_track(9'h0E0, 16'h0005, 16'h0006, 1'b0, 32'h0000_0006);
        send_read();
        drain_results();
    endtask

    task automatic test_delta_wrap();
        send_track(9'h003, 16'h7FFF, 16'h8000, 1'b0, 32'h0000_0010);
        send_track(9'h003, 16'h0001, 16'hFFFF, 1'b1, 32'h0000_0011);
        send_read();
        send_track(9'h003, 16'h0000, 16'h0000, 1'b1, 32'h0000_0012);
        send_read();
        send_track(9'h1FF, 16'h8000, 16'h7FFF, 1'b1, 32'h0000_0000);
        send_read();
        drain_results();
    endtask

    task automatic test_ring_overflow();
        for (int i = 0; i < DEPTH + 3; i++)
            send_track(cur_btn ^ BTN_W'($urandom_range(1, 511)), POS_W'($urandom),
                       POS_W'($urandom), 1'($urandom_range(0, 1)), $urandom);
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            send_read();
            send_track(cur_btn, cur_x + 16'd1, POS_W'($urandom), 1'b0, $urandom);
        end
        send_read();
        drain_results();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int n_track;
        int n_read;
        bit no_idle;
        bit drained;
        sent = 0;
        drained = 0;
        while (sent < n_items)
        begin
            n_track = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 22)
                                                  : $urandom_range(0, 5);
            n_read = $urandom_range(0, 4);
            no_idle = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < n_track; i++)
            begin
                random_track();
                if (!no_idle)
                    idle_gap();
            end
            for (int i = 0; i < n_read; i++)
            begin
                send_read();
                if (!no_idle)
                    idle_gap();
            end
            sent += n_track + n_read;
            if (!drained && sent > n_items / 2)
            begin
                drain_results();
                drained = 1;
            end
        end
    endtask

    initial
    begin
        cur_x = '0;
        cur_y = '0;
        cur_btn = '0;
        cur_stamp = '0;
        rd_ptr = 0;
        wr_ptr = 0;
        ring_full = 1'b0;
        pending = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_read_with_nothing_pending();
        test_coalesce_and_force();
        test_delta_wrap();
        test_ring_overflow();
        test_random_traffic(570);
        start <= 1'b0;
        for (int i = 0; i < 200 && read_results_due.size() != 0; i++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (read_results_due.size() != 0)
            report_mismatch("never arrived, reads left", read_results_due.size(), 0);
        if (mismatches == 0)
            $display("pointer_event_queue_top: match");
        else
            $display("pointer_event_queue_top: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("pointer_event_queue_top: mismatch");
        $finish;
    end

endmodule
